FILE: src/cmts_pkg.sv
// Package: types, codes and constants shared by the clock mode transition sequencer files.
`timescale 1ns / 1ps
`default_nettype none

package cmts_pkg;

    localparam int MODE_W     = 3;
    localparam int SEL_W      = 2;
    localparam int REFDIV_W   = 3;
    localparam int COREDIV_W  = 4;
    localparam int FLASHDIV_W = 3;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 4;
    localparam int MAX_HOPS   = 4;
    localparam int HOP_W      = $clog2(MAX_HOPS);

    // Clock modes, same encoding as the request and the hop word
    typedef enum logic [MODE_W-1:0] {
        M_FEI  = 3'd0,
        M_FEE  = 3'd1,
        M_FBI  = 3'd2,
        M_FBE  = 3'd3,
        M_PEE  = 3'd4,
        M_PBE  = 3'd5,
        M_BLPI = 3'd6,
        M_BLPE = 3'd7
    } t_mode;

    // Output clock source select codes
    localparam logic [SEL_W-1:0] SEL_FLL_PLL = 2'd0;
    localparam logic [SEL_W-1:0] SEL_INT_REF = 2'd1;
    localparam logic [SEL_W-1:0] SEL_EXT_REF = 2'd2;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FLL_REF_DIV  = 2'd0,
        CFG_PLL_CORE_DIV = 2'd1,
        CFG_BYP_CORE_DIV = 2'd2,
        CFG_FLASH_DIV    = 2'd3
    } t_cfg_idx;

    localparam logic [REFDIV_W-1:0]   RST_FLL_REF_DIV  = 3'd4;
    localparam logic [COREDIV_W-1:0]  RST_PLL_CORE_DIV = 4'd1;
    localparam logic [COREDIV_W-1:0]  RST_BYP_CORE_DIV = 4'd0;
    localparam logic [FLASHDIV_W-1:0] RST_FLASH_DIV    = 3'd1;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_WALK = 1'b1
    } t_state;

    typedef struct packed {
        logic [SEL_W-1:0]      clock_select;
        logic                  internal_ref;
        logic                  pll_select;
        logic                  lp_bypass;
        logic [REFDIV_W-1:0]   ref_divider;
        logic [COREDIV_W-1:0]  core_divider;
        logic [FLASHDIV_W-1:0] flash_divider;
    } t_ctrl;

    localparam t_ctrl CTRL_RST = '{
        clock_select:  SEL_FLL_PLL,
        internal_ref:  1'b1,
        pll_select:    1'b0,
        lp_bypass:     1'b0,
        ref_divider:   '0,
        core_divider:  '0,
        flash_divider: '0
    };

    typedef struct packed {
        t_mode step_mode;
        t_ctrl ctrl;
        logic  last_step;
    } t_hop_word;

endpackage

`default_nettype wire

FILE: src/cmts_if.sv
// Interfaces: request, hop result and configuration write channels.
`timescale 1ns / 1ps
`default_nettype none

interface cmts_req_if;
    logic                         valid;
    logic                         ready;
    logic [cmts_pkg::MODE_W-1:0]  target_mode;

    modport source (output valid, output target_mode, input ready);
    modport sink   (input valid, input target_mode, output ready);
endinterface

interface cmts_hop_if;
    logic                             valid;
    logic                             ready;
    logic [cmts_pkg::MODE_W-1:0]      step_mode;
    logic [cmts_pkg::SEL_W-1:0]       clock_select;
    logic                             internal_ref;
    logic                             pll_select;
    logic                             lp_bypass;
    logic [cmts_pkg::REFDIV_W-1:0]    ref_divider_out;
    logic [cmts_pkg::COREDIV_W-1:0]   core_divider_out;
    logic [cmts_pkg::FLASHDIV_W-1:0]  flash_divider_out;
    logic                             last_step;

    modport source (
        output valid, output step_mode, output clock_select, output internal_ref,
        output pll_select, output lp_bypass, output ref_divider_out,
        output core_divider_out, output flash_divider_out, output last_step,
        input ready
    );
    modport sink (
        input valid, input step_mode, input clock_select, input internal_ref,
        input pll_select, input lp_bypass, input ref_divider_out,
        input core_divider_out, input flash_divider_out, input last_step,
        output ready
    );
endinterface

interface cmts_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [cmts_pkg::CFG_IDX_W-1:0]  index;
    logic [cmts_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

FILE: src/clock_mode_transition_sequencer_core.sv
// Top level: clock mode transition sequencer, one mode hop per cycle unless stalled.
`timescale 1ns / 1ps
`default_nettype none
//
// Usage:
//   i_req carries a requested clock mode (one word per request). The block walks
//   the legal mode graph from its current mode to the requested one and puts one
//   word per hop on o_hop: the mode entered, the full control word held after the
//   hop, and last_step on the hop that reaches the requested mode. A request for
//   the current mode is taken and gives no word.
//   i_cfg writes the four divider registers; it is always ready. Write it only
//   while no request is in progress.
// Flow:
//   A request is taken while idle; each hop then passes through the shared
//   next-hop / mode-entry unit, so a request of up to four hops holds
//   i_req.ready low until its walk ends. After the accept the walk state is
//   registered, then the first hop word in the hop output register. That register
//   lets a new request in while the final hop word of the previous one waits.
// Stall: while o_hop is stalled the walk holds and no further hop is computed.
// Reset: mode FEI, internal reference set, other control fields zero; divider
//   registers take their reset values; no word pending.
//
module clock_mode_transition_sequencer_core (
    input  wire         i_clk,
    input  wire         i_rst_n,
    cmts_req_if.sink    i_req,
    cmts_hop_if.source  o_hop,
    cmts_cfg_if.sink    i_cfg
);

    // Next mode on the legal path from cur toward tar
    function automatic cmts_pkg::t_mode next_hop(cmts_pkg::t_mode cur,
                                                 cmts_pkg::t_mode tar);
        cmts_pkg::t_mode hop;
        logic            cur_fll;
        logic            tar_fll;
        cur_fll = (cur <= cmts_pkg::M_FBE);
        tar_fll = (tar <= cmts_pkg::M_FBE);
        hop     = tar;
        if (cur_fll) begin
            if (tar_fll) begin
                hop = tar;
            end else if (tar == cmts_pkg::M_PEE || tar == cmts_pkg::M_PBE) begin
                hop = (cur == cmts_pkg::M_FBE) ? cmts_pkg::M_PBE : cmts_pkg::M_FBE;
            end else if (tar == cmts_pkg::M_BLPI) begin
                hop = (cur == cmts_pkg::M_FBI) ? cmts_pkg::M_BLPI : cmts_pkg::M_FBI;
            end else begin
                hop = (cur == cmts_pkg::M_FBE) ? cmts_pkg::M_BLPE : cmts_pkg::M_FBE;
            end
        end else begin
            unique case (cur)
                cmts_pkg::M_PEE: begin
                    hop = cmts_pkg::M_PBE;
                end
                cmts_pkg::M_PBE: begin
                    if (tar == cmts_pkg::M_PEE || tar == cmts_pkg::M_BLPE) begin
                        hop = tar;
                    end else begin
                        hop = cmts_pkg::M_FBE;
                    end
                end
                cmts_pkg::M_BLPI: begin
                    hop = cmts_pkg::M_FBI;
                end
                default: begin
                    hop = (tar == cmts_pkg::M_PBE || tar == cmts_pkg::M_PEE)
                          ? cmts_pkg::M_PBE : cmts_pkg::M_FBE;
                end
            endcase
        end
        return hop;
    endfunction

    logic [cmts_pkg::REFDIV_W-1:0]   r_fll_ref_div;
    logic [cmts_pkg::COREDIV_W-1:0]  r_pll_core_div;
    logic [cmts_pkg::COREDIV_W-1:0]  r_byp_core_div;
    logic [cmts_pkg::FLASHDIV_W-1:0] r_flash_div;

    cmts_pkg::t_state               r_state, n_state;
    cmts_pkg::t_mode                r_mode, n_mode;
    cmts_pkg::t_mode                r_target, n_target;
    cmts_pkg::t_ctrl                r_ctrl, n_ctrl;
    logic [cmts_pkg::HOP_W-1:0]     r_hops, n_hops;
    logic                           r_out_valid, n_out_valid;
    cmts_pkg::t_hop_word            r_out, n_out;

    cmts_pkg::t_mode                hop;
    cmts_pkg::t_ctrl                hop_ctrl;
    logic                           req_ready;

    localparam logic [cmts_pkg::HOP_W-1:0] HOP_LAST = cmts_pkg::HOP_W'(cmts_pkg::MAX_HOPS - 1);

    // Configuration registers: always ready, data truncated to field width
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fll_ref_div  <= cmts_pkg::RST_FLL_REF_DIV;
            r_pll_core_div <= cmts_pkg::RST_PLL_CORE_DIV;
            r_byp_core_div <= cmts_pkg::RST_BYP_CORE_DIV;
            r_flash_div    <= cmts_pkg::RST_FLASH_DIV;
        end else if (i_cfg.valid) begin
            unique case (cmts_pkg::t_cfg_idx'(i_cfg.index))
                cmts_pkg::CFG_FLL_REF_DIV:  r_fll_ref_div  <= i_cfg.data[cmts_pkg::REFDIV_W-1:0];
                cmts_pkg::CFG_PLL_CORE_DIV: r_pll_core_div <= i_cfg.data[cmts_pkg::COREDIV_W-1:0];
                cmts_pkg::CFG_BYP_CORE_DIV: r_byp_core_div <= i_cfg.data[cmts_pkg::COREDIV_W-1:0];
                cmts_pkg::CFG_FLASH_DIV:    r_flash_div    <= i_cfg.data[cmts_pkg::FLASHDIV_W-1:0];
                default: ;
            endcase
        end
    end

    // Shared hop unit: pick the next mode and build the control word it leaves
    always_comb begin
        hop      = next_hop(r_mode, r_target);
        hop_ctrl = r_ctrl;
        unique case (hop)
            cmts_pkg::M_FEI: begin
                hop_ctrl.clock_select = cmts_pkg::SEL_FLL_PLL;
                hop_ctrl.internal_ref = 1'b1;
                hop_ctrl.pll_select   = 1'b0;
            end
            cmts_pkg::M_FEE: begin
                hop_ctrl.clock_select = cmts_pkg::SEL_FLL_PLL;
                hop_ctrl.internal_ref = 1'b0;
                hop_ctrl.ref_divider  = r_fll_ref_div;
                hop_ctrl.pll_select   = 1'b0;
            end
            cmts_pkg::M_FBI: begin
                hop_ctrl.clock_select = cmts_pkg::SEL_INT_REF;
                hop_ctrl.internal_ref = 1'b1;
                hop_ctrl.pll_select   = 1'b0;
                hop_ctrl.lp_bypass    = 1'b0;
            end
            cmts_pkg::M_FBE: begin
                hop_ctrl.clock_select = cmts_pkg::SEL_EXT_REF;
                hop_ctrl.internal_ref = 1'b0;
                hop_ctrl.ref_divider  = r_fll_ref_div;
                hop_ctrl.pll_select   = 1'b0;
                hop_ctrl.lp_bypass    = 1'b0;
            end
            cmts_pkg::M_PEE: begin
                hop_ctrl.core_divider  = r_pll_core_div;
                hop_ctrl.flash_divider = r_flash_div;
                hop_ctrl.clock_select  = cmts_pkg::SEL_FLL_PLL;
                hop_ctrl.internal_ref  = 1'b0;
                hop_ctrl.pll_select    = 1'b1;
            end
            cmts_pkg::M_PBE: begin
                hop_ctrl.core_divider  = r_byp_core_div;
                hop_ctrl.flash_divider = r_flash_div;
                hop_ctrl.clock_select  = cmts_pkg::SEL_EXT_REF;
                hop_ctrl.internal_ref  = 1'b0;
                hop_ctrl.pll_select    = 1'b1;
                hop_ctrl.lp_bypass     = 1'b0;
            end
            cmts_pkg::M_BLPI: begin
                hop_ctrl.lp_bypass = 1'b1;
            end
            default: begin
                hop_ctrl.clock_select = cmts_pkg::SEL_EXT_REF;
                hop_ctrl.internal_ref = 1'b0;
                hop_ctrl.lp_bypass    = 1'b1;
            end
        endcase
    end

    // Sequencer: take a request when idle, then advance one hop per cycle unless o_hop stalls
    always_comb begin
        n_state     = r_state;
        n_mode      = r_mode;
        n_target    = r_target;
        n_ctrl      = r_ctrl;
        n_hops      = r_hops;
        n_out       = r_out;
        n_out_valid = r_out_valid && !o_hop.ready;
        req_ready   = 1'b0;
        unique case (r_state)
            cmts_pkg::ST_IDLE: begin
                req_ready = 1'b1;
                if (i_req.valid) begin
                    n_target = cmts_pkg::t_mode'(i_req.target_mode);
                    n_hops   = '0;
                    // A request for the current mode is dropped here
                    if (cmts_pkg::t_mode'(i_req.target_mode) != r_mode) begin
                        n_state = cmts_pkg::ST_WALK;
                    end
                end
            end
            cmts_pkg::ST_WALK: begin
                // Hold while the previous hop word is still waiting
                if (!r_out_valid || o_hop.ready) begin
                    n_mode          = hop;
                    n_ctrl          = hop_ctrl;
                    n_out_valid     = 1'b1;
                    n_out.step_mode = hop;
                    n_out.ctrl      = hop_ctrl;
                    n_out.last_step = (hop == r_target);
                    n_hops          = r_hops + 1'b1;
                    if (hop == r_target || r_hops == HOP_LAST) begin
                        n_state = cmts_pkg::ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = cmts_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= cmts_pkg::ST_IDLE;
            r_mode      <= cmts_pkg::M_FEI;
            r_target    <= cmts_pkg::M_FEI;
            r_ctrl      <= cmts_pkg::CTRL_RST;
            r_hops      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_mode      <= n_mode;
            r_target    <= n_target;
            r_ctrl      <= n_ctrl;
            r_hops      <= n_hops;
            r_out_valid <= n_out_valid;
        end
    end

    // Hop word payload needs no reset
    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    assign i_req.ready             = req_ready;
    assign o_hop.valid             = r_out_valid;
    assign o_hop.step_mode         = r_out.step_mode;
    assign o_hop.clock_select      = r_out.ctrl.clock_select;
    assign o_hop.internal_ref      = r_out.ctrl.internal_ref;
    assign o_hop.pll_select        = r_out.ctrl.pll_select;
    assign o_hop.lp_bypass         = r_out.ctrl.lp_bypass;
    assign o_hop.ref_divider_out   = r_out.ctrl.ref_divider;
    assign o_hop.core_divider_out  = r_out.ctrl.core_divider;
    assign o_hop.flash_divider_out = r_out.ctrl.flash_divider;
    assign o_hop.last_step         = r_out.last_step;

    // While walking the target has not yet been reached
    a_walk_not_at_target: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == cmts_pkg::ST_WALK |-> r_mode != r_target)
        else $error("walk active with mode already at target");

    // A pending word that is not the final hop means the walk is still running
    a_mid_hop_walking: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !r_out.last_step |-> r_state == cmts_pkg::ST_WALK)
        else $error("non-final hop word pending outside a walk");

    // While a hop word is pending, the held control word and mode match it
    a_word_matches_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out.ctrl == r_ctrl && r_out.step_mode == r_mode))
        else $error("hop word disagrees with held state");

    // A request for the current mode starts no walk
    a_same_mode_no_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.valid && req_ready && cmts_pkg::t_mode'(i_req.target_mode) == r_mode
        |=> r_state == cmts_pkg::ST_IDLE)
        else $error("walk started for the current mode");

endmodule

`default_nettype wire

FILE: sim/tb_clock_mode_transition_sequencer_core.sv
// Testbench: mode walks and divider writes of the clock mode transition sequencer, checked per hop.
`timescale 1ns / 1ps

module tb_clock_mode_transition_sequencer_core;

    // Slack held after the last due hop word has arrived
    localparam int DRAIN_CYCLES = 12;
    localparam int LIMIT_CYCLES = 200000;
    localparam int RAND_PHASES  = 6;
    localparam int PHASE_ITEMS  = 25;

    logic i_clk = 1'b0;
    logic i_rst_n;

    cmts_req_if req_ch ();
    cmts_hop_if hop_ch ();
    cmts_cfg_if cfg_ch ();

    clock_mode_transition_sequencer_core u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_hop   (hop_ch),
        .i_cfg   (cfg_ch)
    );

    // Clock: 4 ns period
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Mode walk predictor: its own copy of the divider registers, the
    // current mode and the held control word.
    // ------------------------------------------------------------------
    logic [cmts_pkg::REFDIV_W-1:0]   div_fll_ref;
    logic [cmts_pkg::COREDIV_W-1:0]  div_pll_core;
    logic [cmts_pkg::COREDIV_W-1:0]  div_byp_core;
    logic [cmts_pkg::FLASHDIV_W-1:0] div_flash;
    cmts_pkg::t_mode                 mode_now;
    cmts_pkg::t_ctrl                 ctrl_now;

    // Hop words still owed by the block, oldest first
    cmts_pkg::t_hop_word hop_words_due[$];

    int mismatch_count = 0;
    int cycle_count    = 0;
    bit gaps_on        = 1'b0;  // sender idles in random bursts
    bit stalls_on      = 1'b0;  // receiver stalls in random bursts
    int stall_left     = 0;

    // The FLL group is FEI, FEE, FBI and FBE
    function automatic bit fll_group(cmts_pkg::t_mode m);
        return m <= cmts_pkg::M_FBE;
    endfunction

    // Pick the next legal hop from cur toward tgt
    function automatic cmts_pkg::t_mode step_toward(cmts_pkg::t_mode cur,
                                                    cmts_pkg::t_mode tgt);
        if (cur == tgt) return tgt;
        if (fll_group(cur)) begin
            if (fll_group(tgt)) return tgt;
            if (tgt == cmts_pkg::M_PEE || tgt == cmts_pkg::M_PBE)
                return (cur == cmts_pkg::M_FBE) ? cmts_pkg::M_PBE : cmts_pkg::M_FBE;
            if (tgt == cmts_pkg::M_BLPI)
                return (cur == cmts_pkg::M_FBI) ? cmts_pkg::M_BLPI : cmts_pkg::M_FBI;
            return (cur == cmts_pkg::M_FBE) ? cmts_pkg::M_BLPE : cmts_pkg::M_FBE;
        end
        case (cur)
            cmts_pkg::M_PEE: return cmts_pkg::M_PBE;
            cmts_pkg::M_PBE: begin
                if (tgt == cmts_pkg::M_PEE) return cmts_pkg::M_PEE;
                if (tgt == cmts_pkg::M_BLPE) return cmts_pkg::M_BLPE;
                return cmts_pkg::M_FBE;
            end
            cmts_pkg::M_BLPI: return cmts_pkg::M_FBI;
            default: return (tgt == cmts_pkg::M_PBE || tgt == cmts_pkg::M_PEE)
                            ? cmts_pkg::M_PBE : cmts_pkg::M_FBE;
        endcase
    endfunction

    // Apply the control word writes of entering mode m; other fields hold
    task automatic enter_mode(cmts_pkg::t_mode m);
        case (m)
            cmts_pkg::M_FEI: begin
                ctrl_now.clock_select = cmts_pkg::SEL_FLL_PLL;
                ctrl_now.internal_ref = 1'b1;
                ctrl_now.pll_select   = 1'b0;
            end
            cmts_pkg::M_FEE: begin
                ctrl_now.clock_select = cmts_pkg::SEL_FLL_PLL;
                ctrl_now.internal_ref = 1'b0;
                ctrl_now.ref_divider  = div_fll_ref;
                ctrl_now.pll_select   = 1'b0;
            end
            cmts_pkg::M_FBI: begin
                ctrl_now.clock_select = cmts_pkg::SEL_INT_REF;
                ctrl_now.internal_ref = 1'b1;
                ctrl_now.pll_select   = 1'b0;
                ctrl_now.lp_bypass    = 1'b0;
            end
            cmts_pkg::M_FBE: begin
                ctrl_now.clock_select = cmts_pkg::SEL_EXT_REF;
                ctrl_now.internal_ref = 1'b0;
                ctrl_now.ref_divider  = div_fll_ref;
                ctrl_now.pll_select   = 1'b0;
                ctrl_now.lp_bypass    = 1'b0;
            end
            cmts_pkg::M_PEE: begin
                ctrl_now.core_divider  = div_pll_core;
                ctrl_now.flash_divider = div_flash;
                ctrl_now.clock_select  = cmts_pkg::SEL_FLL_PLL;
                ctrl_now.internal_ref  = 1'b0;
                ctrl_now.pll_select    = 1'b1;
            end
            cmts_pkg::M_PBE: begin
                ctrl_now.core_divider  = div_byp_core;
                ctrl_now.flash_divider = div_flash;
                ctrl_now.clock_select  = cmts_pkg::SEL_EXT_REF;
                ctrl_now.internal_ref  = 1'b0;
                ctrl_now.pll_select    = 1'b1;
                ctrl_now.lp_bypass     = 1'b0;
            end
            cmts_pkg::M_BLPI: begin
                ctrl_now.lp_bypass = 1'b1;
            end
            default: begin
                ctrl_now.clock_select = cmts_pkg::SEL_EXT_REF;
                ctrl_now.internal_ref = 1'b0;
                ctrl_now.lp_bypass    = 1'b1;
            end
        endcase
        mode_now = m;
    endtask

    // Walk toward tgt and queue one hop word per hop; at most four hops
    task automatic walk_to_mode(cmts_pkg::t_mode tgt);
        cmts_pkg::t_hop_word w;
        cmts_pkg::t_mode     hop;
        int                  n;
        n = 0;
        while (mode_now != tgt && n < cmts_pkg::MAX_HOPS) begin
            hop = step_toward(mode_now, tgt);
            enter_mode(hop);
            w.step_mode = hop;
            w.ctrl      = ctrl_now;
            w.last_step = (hop == tgt);
            hop_words_due.push_back(w);
            n++;
        end
    endtask

    // ------------------------------------------------------------------
    // Mismatch reporting and hop word checking
    // ------------------------------------------------------------------
    task automatic report_mismatch(string msg);
        $display("[%0t] error: %s", $realtime, msg);
        mismatch_count++;
    endtask

    task automatic check_field(string name, int got, int want);
        if (got != want)
            report_mismatch($sformatf("hop field %s got %0d, want %0d", name, got, want));
    endtask

    task automatic check_hop_word();
        cmts_pkg::t_hop_word w;
        if (hop_words_due.size() == 0) begin
            report_mismatch($sformatf("hop word with none due, step_mode %0d",
                                      hop_ch.step_mode));
        end else begin
            w = hop_words_due.pop_front();
            check_field("step_mode", int'(hop_ch.step_mode), int'(w.step_mode));
            check_field("clock_select", int'(hop_ch.clock_select),
                        int'(w.ctrl.clock_select));
            check_field("internal_ref", int'(hop_ch.internal_ref),
                        int'(w.ctrl.internal_ref));
            check_field("pll_select", int'(hop_ch.pll_select), int'(w.ctrl.pll_select));
            check_field("lp_bypass", int'(hop_ch.lp_bypass), int'(w.ctrl.lp_bypass));
            check_field("ref_divider_out", int'(hop_ch.ref_divider_out),
                        int'(w.ctrl.ref_divider));
            check_field("core_divider_out", int'(hop_ch.core_divider_out),
                        int'(w.ctrl.core_divider));
            check_field("flash_divider_out", int'(hop_ch.flash_divider_out),
                        int'(w.ctrl.flash_divider));
            check_field("last_step", int'(hop_ch.last_step), int'(w.last_step));
        end
    endtask

    // Sample the hop channel at the edge, then drive ready for the next cycle.
    // Stalls come in random bursts when enabled.
    always @(posedge i_clk) begin
        if (i_rst_n && hop_ch.valid && hop_ch.ready) check_hop_word();
        if (!i_rst_n) begin
            stall_left   <= 0;
            hop_ch.ready <= 1'b0;
        end else if (stall_left != 0) begin
            stall_left   <= stall_left - 1;
            hop_ch.ready <= 1'b0;
        end else if (stalls_on && $urandom_range(0, 5) == 0) begin
            stall_left   <= $urandom_range(0, 7);
            hop_ch.ready <= 1'b0;
        end else begin
            hop_ch.ready <= 1'b1;
        end
    end

    // Watchdog: end the run if the block hangs
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers. Every task is entered and left at a rising edge.
    // ------------------------------------------------------------------

    // Send one request word; valid stays high after the accept so that
    // back-to-back words follow without a gap. Predict at the accept edge.
    task automatic send_request(cmts_pkg::t_mode tgt);
        int gap;
        if (gaps_on && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 8);
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_ch.valid       <= 1'b1;
        req_ch.target_mode <= tgt;
        @(posedge i_clk);
        while (!req_ch.ready) @(posedge i_clk);
        walk_to_mode(tgt);
    endtask

    // Drop valid, let every due hop word arrive, then hold for the tail
    // of a request that gives no word.
    task automatic wait_drained();
        req_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (hop_words_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Write one divider register; only called with the block idle
    task automatic write_reg(cmts_pkg::t_cfg_idx idx, logic [cmts_pkg::CFG_DATA_W-1:0] val);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= val;
        @(posedge i_clk);
        while (!cfg_ch.ready) @(posedge i_clk);
        case (idx)
            cmts_pkg::CFG_FLL_REF_DIV:  div_fll_ref  = val[cmts_pkg::REFDIV_W-1:0];
            cmts_pkg::CFG_PLL_CORE_DIV: div_pll_core = val[cmts_pkg::COREDIV_W-1:0];
            cmts_pkg::CFG_BYP_CORE_DIV: div_byp_core = val[cmts_pkg::COREDIV_W-1:0];
            default:                    div_flash    = val[cmts_pkg::FLASHDIV_W-1:0];
        endcase
        cfg_ch.valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic write_all_regs(logic [cmts_pkg::CFG_DATA_W-1:0] fll_ref,
                                  logic [cmts_pkg::CFG_DATA_W-1:0] pll_core,
                                  logic [cmts_pkg::CFG_DATA_W-1:0] byp_core,
                                  logic [cmts_pkg::CFG_DATA_W-1:0] flash);
        write_reg(cmts_pkg::CFG_FLL_REF_DIV,  fll_ref);
        write_reg(cmts_pkg::CFG_PLL_CORE_DIV, pll_core);
        write_reg(cmts_pkg::CFG_BYP_CORE_DIV, byp_core);
        write_reg(cmts_pkg::CFG_FLASH_DIV,    flash);
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Right after reset the block sits in FEI: a request for FEI gives no
    // word; the first real hop shows the divider fields of the reset control word.
    task automatic test_request_current_mode();
        send_request(cmts_pkg::M_FEI);
        send_request(cmts_pkg::M_FEI);
        send_request(cmts_pkg::M_FBI);
        send_request(cmts_pkg::M_FBI);
        wait_drained();
    endtask

    // Cover every target, the four-hop walks in both directions, and
    // repeated requests for the mode already held.
    task automatic test_mode_graph();
        send_request(cmts_pkg::M_FEE);
        send_request(cmts_pkg::M_FBE);
        send_request(cmts_pkg::M_PEE);
        send_request(cmts_pkg::M_BLPI);   // PEE to BLPI: four hops
        send_request(cmts_pkg::M_PEE);    // BLPI to PEE: four hops
        send_request(cmts_pkg::M_BLPE);
        send_request(cmts_pkg::M_FEI);
        send_request(cmts_pkg::M_BLPE);
        send_request(cmts_pkg::M_BLPI);
        send_request(cmts_pkg::M_PBE);
        send_request(cmts_pkg::M_FBI);
        send_request(cmts_pkg::M_BLPI);
        send_request(cmts_pkg::M_FEE);
        send_request(cmts_pkg::M_BLPE);
        send_request(cmts_pkg::M_BLPE);
        send_request(cmts_pkg::M_PBE);
        send_request(cmts_pkg::M_FEI);
        wait_drained();
    endtask

    // Drive the divider registers to their extremes; data wider than a
    // 3-bit register keeps only its low bits.
    task automatic test_divider_extremes();
        write_all_regs(4'd15, 4'd15, 4'd15, 4'd15);
        send_request(cmts_pkg::M_FEE);
        send_request(cmts_pkg::M_PBE);
        send_request(cmts_pkg::M_PEE);
        send_request(cmts_pkg::M_FBE);
        wait_drained();
        write_all_regs(4'd8, 4'd0, 4'd0, 4'd8);
        send_request(cmts_pkg::M_PEE);
        send_request(cmts_pkg::M_BLPE);
        send_request(cmts_pkg::M_PBE);
        send_request(cmts_pkg::M_FEE);
        wait_drained();
    endtask

    // Random walks over several divider settings; idling and stalls are on
    // in the first phase, random in the middle ones and off in the last two.
    task automatic test_random_walks();
        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            write_all_regs(cmts_pkg::CFG_DATA_W'($urandom_range(0, 15)),
                           cmts_pkg::CFG_DATA_W'($urandom_range(0, 15)),
                           cmts_pkg::CFG_DATA_W'($urandom_range(0, 15)),
                           cmts_pkg::CFG_DATA_W'($urandom_range(0, 15)));
            if (ph == 0) begin
                gaps_on   = 1'b1;
                stalls_on = 1'b1;
            end else if (ph < RAND_PHASES - 2) begin
                gaps_on   = 1'($urandom_range(0, 1));
                stalls_on = 1'($urandom_range(0, 1));
            end else begin
                gaps_on   = 1'b0;
                stalls_on = 1'b0;
            end
            for (int i = 0; i < PHASE_ITEMS; i++) begin
                // Hold off mid-run until the block has emptied its hop words
                if (ph == 2 && i == PHASE_ITEMS / 2) wait_drained();
                send_request(cmts_pkg::t_mode'($urandom_range(0, 7)));
            end
            wait_drained();
        end
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        i_rst_n            <= 1'b0;
        req_ch.valid       <= 1'b0;
        req_ch.target_mode <= cmts_pkg::M_FEI;
        cfg_ch.valid       <= 1'b0;
        cfg_ch.index       <= cmts_pkg::CFG_FLL_REF_DIV;
        cfg_ch.data        <= '0;

        div_fll_ref  = cmts_pkg::RST_FLL_REF_DIV;
        div_pll_core = cmts_pkg::RST_PLL_CORE_DIV;
        div_byp_core = cmts_pkg::RST_BYP_CORE_DIV;
        div_flash    = cmts_pkg::RST_FLASH_DIV;
        mode_now     = cmts_pkg::M_FEI;
        ctrl_now     = cmts_pkg::CTRL_RST;

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_request_current_mode();
        test_mode_graph();
        test_divider_extremes();
        test_random_walks();

        wait_drained();
        if (hop_words_due.size() != 0)
            report_mismatch($sformatf("%0d hop words never arrived", hop_words_due.size()));
        if (mismatch_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

FILE: clock_mode_transition_sequencer_core.f
src/cmts_pkg.sv
src/cmts_if.sv
src/clock_mode_transition_sequencer_core.sv
sim/tb_clock_mode_transition_sequencer_core.sv
